>>> rtl/bst_pkg.sv
// Shared constants and control types for the bounded set table.
package bst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ELEM_W       = 32;
    localparam int CMD_W        = 2;
    localparam int COUNT_OUT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } bst_ctrl_t;

    typedef struct packed {
        logic scan_last;
    } bst_stat_t;

endpackage

>>> rtl/bst_cmd_if.sv
// Request channel carrying one command and its element per transfer.
interface bst_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [bst_pkg::CMD_W-1:0]        command;
    logic signed [bst_pkg::ELEM_W-1:0] element;

    modport source (output valid, output command, output element, input ready);
    modport sink (input valid, input command, input element, output ready);
endinterface

>>> rtl/bst_rsp_if.sv
// Result channel carrying the outcome and element count per transfer.
interface bst_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            succeeded;
    logic                            table_full;
    logic [bst_pkg::COUNT_OUT_W-1:0] element_count;

    modport source (output valid, output succeeded, output table_full,
                    output element_count, input ready);
    modport sink (input valid, input succeeded, input table_full,
                  input element_count, output ready);
endinterface

>>> rtl/bounded_set_table.sv
// Bounded set table: one command per transfer, one result transfer per command.
// A command is loaded in idle, then scans every slot of the single-port slot memory, passes a
// drain state and commits; commit waits while an earlier result is still pending.
// A new command is taken only once the previous one has committed; the result
// register lets a result wait for the sink while the next command scans.
// Reset clears all valid bits and the count at once; slot contents are not cleared.
module bounded_set_table
#(
    parameter int CAPACITY = bst_pkg::CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    bst_cmd_if.sink   request,
    bst_rsp_if.source result
);

    bst_pkg::bst_ctrl_t ctrl;
    bst_pkg::bst_stat_t stat;

    bst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    bst_dpath #(.CAPACITY(CAPACITY)) u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .command       (request.command),
        .element       ($unsigned(request.element)),
        .succeeded     (result.succeeded),
        .table_full    (result.table_full),
        .element_count (result.element_count)
    );

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> (!result.valid || result.ready))
        else $error("commit while a result is still pending");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request taken while a command is in progress");

    a_full_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.table_full) |-> !result.succeeded)
        else $error("refused insert reported as success");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.table_full)
            |-> (result.element_count == bst_pkg::COUNT_OUT_W'(CAPACITY)))
        else $error("refused insert with a table that is not full");

endmodule

>>> rtl/bst_ctrl.sv
// Sequencing state machine for the bounded set table.
module bst_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bst_pkg::bst_stat_t stat,
    output bst_pkg::bst_ctrl_t ctrl
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    ctrl.commit    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/bst_dpath.sv
// Slot memory, valid bits, scan compare logic and result registers.
module bst_dpath
#(
    parameter int CAPACITY = bst_pkg::CAPACITY_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bst_pkg::bst_ctrl_t              ctrl,
    output bst_pkg::bst_stat_t              stat,
    input  logic [bst_pkg::CMD_W-1:0]       command,
    input  logic [bst_pkg::ELEM_W-1:0]      element,
    output logic                            succeeded,
    output logic                            table_full,
    output logic [bst_pkg::COUNT_OUT_W-1:0] element_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [bst_pkg::ELEM_W-1:0] slot_mem [CAPACITY];
    logic [CAPACITY-1:0]        slot_valid_reg;

    logic [bst_pkg::CMD_W-1:0]  cmd_reg;
    logic [bst_pkg::ELEM_W-1:0] elem_reg;
    logic [IDX_W-1:0]           rd_addr_reg;
    logic [bst_pkg::ELEM_W-1:0] rd_data_reg;
    logic                       rd_live_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic                       cmp_en_reg;
    logic                       hit_reg;
    logic [IDX_W-1:0]           hit_idx_reg;
    logic                       free_reg;
    logic [IDX_W-1:0]           free_idx_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       succ_reg;
    logic                       full_reg;

    logic                       do_insert;
    logic                       do_remove;
    logic                       succ_next;
    logic                       full_next;

    assign stat.scan_last = (rd_addr_reg == IDX_W'(CAPACITY - 1));

    always_comb
    begin
        do_insert = 1'b0;
        do_remove = 1'b0;
        succ_next = 1'b0;
        full_next = 1'b0;
        unique case (cmd_reg)
            bst_pkg::CMD_INSERT:
            begin
                if (!hit_reg)
                begin
                    do_insert = free_reg;
                    succ_next = free_reg;
                    full_next = !free_reg;
                end
            end
            bst_pkg::CMD_REMOVE:
            begin
                do_remove = hit_reg;
                succ_next = hit_reg;
            end
            bst_pkg::CMD_LOOKUP:
            begin
                succ_next = hit_reg;
            end
            default:
            begin
                succ_next = 1'b0;
            end
        endcase
    end

    // Memory port: one scan read per cycle, one write at the commit of an insert.
    always_ff @(posedge clk)
    begin
        if (ctrl.scan_step)
        begin
            rd_data_reg <= slot_mem[rd_addr_reg];
        end
        if (ctrl.commit && do_insert)
        begin
            slot_mem[free_idx_reg] <= elem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= command;
            elem_reg <= element;
        end
        if (ctrl.scan_step)
        begin
            rd_live_reg <= slot_valid_reg[rd_addr_reg];
            rd_idx_reg  <= rd_addr_reg;
        end
        if (cmp_en_reg && rd_live_reg && (rd_data_reg == elem_reg) && !hit_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (cmp_en_reg && !rd_live_reg && !free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (ctrl.commit)
        begin
            succ_reg <= succ_next;
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            count_reg      <= '0;
            rd_addr_reg    <= '0;
            cmp_en_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= ctrl.scan_step;
            if (ctrl.load)
            begin
                rd_addr_reg <= '0;
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
            end
            else
            begin
                if (ctrl.scan_step)
                begin
                    rd_addr_reg <= stat.scan_last ? '0 : rd_addr_reg + IDX_W'(1);
                end
                if (cmp_en_reg && rd_live_reg && (rd_data_reg == elem_reg))
                begin
                    hit_reg <= 1'b1;
                end
                if (cmp_en_reg && !rd_live_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (ctrl.commit && do_insert)
            begin
                slot_valid_reg[free_idx_reg] <= 1'b1;
                count_reg                    <= count_reg + CNT_W'(1);
            end
            else if (ctrl.commit && do_remove)
            begin
                slot_valid_reg[hit_idx_reg] <= 1'b0;
                count_reg                   <= count_reg - CNT_W'(1);
            end
        end
    end

    assign succeeded     = succ_reg;
    assign table_full    = full_reg;
    assign element_count = bst_pkg::COUNT_OUT_W'(count_reg);

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the bounded set table, comparing each result transfer with a prediction.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bst_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam int POOL_SIZE = 20;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ELEM_W-1:0] element;
    } set_cmd_t;

    typedef struct packed {
        logic                   succeeded;
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] element_count;
    } set_outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    bst_cmd_if req_if();
    bst_rsp_if rsp_if();

    bounded_set_table #(.CAPACITY(CAPACITY)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .request(req_if),
        .result(rsp_if)
    );

    set_cmd_t          pending_q[$];
    set_outcome_t      outcome_q[$];
    logic [ELEM_W-1:0] model_value [CAPACITY];
    logic              model_valid [CAPACITY];
    int                model_count = 0;
    logic [ELEM_W-1:0] pool [POOL_SIZE];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   sent_count = 0;
    int   taken_count = 0;
    logic req_taken = 1'b0;
    int   error_count = 0;
    int   result_count = 0;
    int   full_refusals = 0;
    int   lookup_hits = 0;
    int   peak_count = 0;

    always #5 clk = ~clk;

    function automatic set_outcome_t predict_set_command(input set_cmd_t item);
        set_outcome_t res;
        int hit;
        int free_slot;
        res = '0;
        hit = CAPACITY;
        free_slot = CAPACITY;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (model_valid[i] && model_value[i] == item.element)
                hit = i;
            if (!model_valid[i])
                free_slot = i;
        end
        case (item.command)
            CMD_INSERT:
            begin
                if (hit == CAPACITY)
                begin
                    if (free_slot < CAPACITY)
                    begin
                        model_value[free_slot] = item.element;
                        model_valid[free_slot] = 1'b1;
                        model_count++;
                        res.succeeded = 1'b1;
                    end
                    else
                    begin
                        res.table_full = 1'b1;
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (hit < CAPACITY)
                begin
                    model_valid[hit] = 1'b0;
                    if (model_count > 0)
                        model_count--;
                    res.succeeded = 1'b1;
                end
            end
            CMD_LOOKUP:
            begin
                res.succeeded = (hit < CAPACITY);
            end
            default:
            begin
            end
        endcase
        res.element_count = model_count[COUNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic queue_command(input logic [CMD_W-1:0] command, input logic [ELEM_W-1:0] element);
        set_cmd_t item;
        item.command = command;
        item.element = element;
        pending_q.push_back(item);
    endtask

    task automatic queue_random_commands(input int count);
        int insert_pct;
        int roll;
        logic [CMD_W-1:0] command;
        logic [ELEM_W-1:0] element;
        insert_pct = 50;
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            case ($urandom_range(7))
                0: pool[p] = 32'h8000_0000;
                1: pool[p] = 32'h7FFF_FFFF;
                2: pool[p] = 32'hFFFF_FFFF;
                default: pool[p] = $urandom();
            endcase
        end
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                insert_pct = $urandom_range(70, 25);
            roll = $urandom_range(99);
            if (roll < insert_pct)
                command = CMD_INSERT;
            else if (roll < 95)
                command = ($urandom_range(1) == 0) ? CMD_REMOVE : CMD_LOOKUP;
            else
                command = CMD_RESERVED;
            if ($urandom_range(9) == 0)
                element = $urandom();
            else
                element = pool[$urandom_range(POOL_SIZE - 1)];
            queue_command(command, element);
        end
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || taken_count != sent_count || outcome_q.size() != 0);
    endtask

    always @(posedge clk)
    begin : check_proc
        set_outcome_t want;
        set_outcome_t got;
        set_cmd_t seen;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= req_if.valid && req_if.ready;
            if (rsp_if.valid && rsp_if.ready)
            begin
                result_count++;
                if (outcome_q.size() == 0)
                begin
                    $error("result transfer arrived with no command outstanding");
                    error_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    got.succeeded = rsp_if.succeeded;
                    got.table_full = rsp_if.table_full;
                    got.element_count = rsp_if.element_count;
                    if (got.succeeded !== want.succeeded)
                    begin
                        $error("succeeded: expected %0b, actual %0b", want.succeeded, got.succeeded);
                        error_count++;
                    end
                    if (got.table_full !== want.table_full)
                    begin
                        $error("table_full: expected %0b, actual %0b", want.table_full, got.table_full);
                        error_count++;
                    end
                    if (got.element_count !== want.element_count)
                    begin
                        $error("element_count: expected %0d, actual %0d",
                               want.element_count, got.element_count);
                        error_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                seen.command = req_if.command;
                seen.element = req_if.element;
                want = predict_set_command(seen);
                outcome_q.push_back(want);
                taken_count++;
                if (want.table_full)
                    full_refusals++;
                if (seen.command == CMD_LOOKUP && want.succeeded)
                    lookup_hits++;
                if (model_count > peak_count)
                    peak_count = model_count;
            end
        end
    end

    always @(negedge clk)
    begin : drive_proc
        set_cmd_t item;
        if (rst_n)
        begin
            if (!(req_if.valid && !req_taken))
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item = pending_q.pop_front();
                    sent_count++;
                    req_if.command <= item.command;
                    req_if.element <= item.element;
                    req_if.valid <= 1'b1;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        req_if.valid = 1'b0;
        req_if.command = CMD_INSERT;
        req_if.element = '0;
        rsp_if.ready = 1'b0;
        rst_n = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            model_value[i] = '0;
            model_valid[i] = 1'b0;
        end
        send_idle_pct = 13;
        recv_idle_pct = 75;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_command(CMD_INSERT, 32'h8000_0000);
        queue_command(CMD_INSERT, 32'h7FFF_FFFF);
        queue_command(CMD_INSERT, 32'h0000_0000);
        queue_command(CMD_INSERT, 32'hFFFF_FFFF);
        queue_command(CMD_INSERT, 32'h0000_0000);
        queue_command(CMD_LOOKUP, 32'h8000_0000);
        queue_command(CMD_LOOKUP, 32'h0000_0005);
        queue_command(CMD_REMOVE, 32'h0000_0005);
        queue_command(CMD_REMOVE, 32'h7FFF_FFFF);
        queue_command(CMD_RESERVED, 32'hFFFF_FFFF);
        for (int v = 1; v <= 13; v++)
            queue_command(CMD_INSERT, v);
        queue_command(CMD_INSERT, 32'h0000_0064);
        queue_command(CMD_INSERT, 32'h0000_0001);
        queue_command(CMD_REMOVE, 32'h8000_0000);
        queue_command(CMD_INSERT, 32'hAAAA_AAAA);
        queue_command(CMD_LOOKUP, 32'hAAAA_AAAA);
        wait_for_drain();

        queue_random_commands(170);
        wait_for_drain();

        send_idle_pct = 75;
        recv_idle_pct = 13;
        queue_random_commands(170);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_commands(170);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results from directed and random commands under three pacing profiles.",
                 result_count);
        $display("Full-table refusals: %0d, lookup hits: %0d, peak occupancy: %0d of %0d.",
                 full_refusals, lookup_hits, peak_count, CAPACITY);
        if (error_count == 0 && outcome_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
